// File: rtl/png_cv_pkg.sv
// Shared types, constants and functions for the PNG chunk validator.
// No dependencies; imported by every module of the block.
`default_nettype none

package png_cv_pkg;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_INVALID     = 3'd1,
    ST_CRC         = 3'd2,
    ST_BUDGET      = 3'd3,
    ST_UNSUPPORTED = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    PH_LENGTH = 4'b0001,
    PH_TYPE   = 4'b0010,
    PH_DATA   = 4'b0100,
    PH_CRC    = 4'b1000
  } phase_e;

  typedef struct packed {
    status_e     status;
    logic [31:0] image_width;
    logic [31:0] image_height;
  } res_t;

  localparam int unsigned SeenIhdr = 0;
  localparam int unsigned SeenIdat = 1;
  localparam int unsigned SeenIend = 2;

  localparam logic [31:0] TypeIhdr = 32'h4948_4452;
  localparam logic [31:0] TypeIdat = 32'h4944_4154;
  localparam logic [31:0] TypeIend = 32'h4945_4E44;
  localparam logic [31:0] CrcPoly  = 32'hEDB8_8320;
  localparam logic [31:0] CrcInit  = 32'hFFFF_FFFF;
  localparam logic [31:0] IhdrLen  = 32'd13;

  localparam logic [1:0]  CfgMaxDim = 2'd0;
  localparam logic [1:0]  CfgMaxPix = 2'd1;
  localparam logic [31:0] MaxDimReset = 32'd16384;
  localparam logic [62:0] MaxPixReset = 63'd67108864;

  function automatic logic [7:0] sig_byte(input logic [2:0] idx);
    logic [7:0] r;
    case (idx)
      3'd0:    r = 8'd137;
      3'd1:    r = 8'd80;
      3'd2:    r = 8'd78;
      3'd3:    r = 8'd71;
      3'd4:    r = 8'd13;
      3'd5:    r = 8'd10;
      3'd6:    r = 8'd26;
      3'd7:    r = 8'd10;
      default: r = 8'd0;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      r = (r >> 1) ^ (r[0] ? CrcPoly : 32'd0);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/png_cv_budget.sv
// Pixel budget check: registered width*height product, then registered compare.
// Depends on png_cv_pkg.
`default_nettype none

module png_cv_budget
  import png_cv_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic [31:0] hdr_w_i,
  input  wire logic [31:0] hdr_h_i,
  input  wire logic [62:0] max_pix_i,
  output logic             over_o
);

  logic [63:0] pixels_q;
  logic        over_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pixels_q <= 64'd0;
      over_q   <= 1'b0;
    end else begin
      pixels_q <= hdr_w_i * hdr_h_i;
      over_q   <= pixels_q > {1'b0, max_pix_i};
    end
  end

  assign over_o = over_q;

endmodule

`default_nettype wire

// File: rtl/png_cv_parser.sv
// Signature check, chunk framing, CRC-32 and header checks, one byte a step.
// Depends on png_cv_pkg; takes the budget flag from png_cv_budget.
`default_nettype none

module png_cv_parser
  import png_cv_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        step_i,
  input  wire logic [7:0]  byte_i,
  input  wire logic        last_i,
  input  wire logic [31:0] max_dim_i,
  input  wire logic        over_i,
  output logic [31:0]      hdr_w_o,
  output logic [31:0]      hdr_h_o,
  output res_t             res_o
);

  logic [3:0]  sig_cnt_q, sig_cnt_d;
  phase_e      phase_q, phase_d;
  logic [1:0]  fcnt_q, fcnt_d;
  logic [31:0] len_q, len_d;
  logic [31:0] rem_q, rem_d;
  logic [31:0] type_q, type_d;
  logic [31:0] crc_q, crc_d;
  logic [31:0] scrc_q, scrc_d;
  logic [31:0] hw_q, hw_d;
  logic [31:0] hh_q, hh_d;
  logic [23:0] meth_q, meth_d;
  logic [2:0]  seen_q, seen_d;
  status_e     err_q, err_d;
  logic [31:0] idx;
  status_e     chk;
  status_e     fin;

  always_comb begin
    sig_cnt_d = sig_cnt_q;
    phase_d   = phase_q;
    fcnt_d    = fcnt_q;
    len_d     = len_q;
    rem_d     = rem_q;
    type_d    = type_q;
    crc_d     = crc_q;
    scrc_d    = scrc_q;
    hw_d      = hw_q;
    hh_d      = hh_q;
    meth_d    = meth_q;
    seen_d    = seen_q;
    err_d     = err_q;
    idx       = len_q - rem_q;
    chk       = ST_OK;
    if (err_q == ST_OK) begin
      if (!sig_cnt_q[3]) begin
        if (byte_i != sig_byte(sig_cnt_q[2:0])) begin
          err_d = ST_INVALID;
        end else begin
          sig_cnt_d = sig_cnt_q + 4'd1;
        end
      end else if (seen_q[SeenIend]) begin
        err_d = ST_INVALID;
      end else begin
        case (phase_q)
          PH_LENGTH: begin
            len_d  = {len_q[23:0], byte_i};
            fcnt_d = fcnt_q + 2'd1;
            if (fcnt_q == 2'd3) begin
              phase_d = PH_TYPE;
              crc_d   = CrcInit;
            end
          end
          PH_TYPE: begin
            type_d = {type_q[23:0], byte_i};
            crc_d  = crc_byte(crc_q, byte_i);
            fcnt_d = fcnt_q + 2'd1;
            if (fcnt_q == 2'd3) begin
              if (len_q == 32'd0) begin
                phase_d = PH_CRC;
              end else begin
                phase_d = PH_DATA;
                rem_d   = len_q;
              end
            end
          end
          PH_DATA: begin
            if (!seen_q[SeenIhdr]) begin
              if (idx < 32'd4) begin
                hw_d = {hw_q[23:0], byte_i};
              end else if (idx < 32'd8) begin
                hh_d = {hh_q[23:0], byte_i};
              end else if (idx >= 32'd10 && idx < 32'd13) begin
                meth_d = {meth_q[15:0], byte_i};
              end
            end
            crc_d = crc_byte(crc_q, byte_i);
            rem_d = rem_q - 32'd1;
            if (rem_q == 32'd1) begin
              phase_d = PH_CRC;
            end
          end
          PH_CRC: begin
            scrc_d = {scrc_q[23:0], byte_i};
            fcnt_d = fcnt_q + 2'd1;
            if (fcnt_q == 2'd3) begin
              phase_d = PH_LENGTH;
              if (~crc_q != scrc_d) begin
                chk = ST_CRC;
              end else if (!seen_q[SeenIhdr]) begin
                if (type_q != TypeIhdr || len_q != IhdrLen) begin
                  chk = ST_INVALID;
                end else if (hw_q == 32'd0 || hh_q == 32'd0 ||
                             hw_q > max_dim_i || hh_q > max_dim_i) begin
                  chk = ST_INVALID;
                end else if (over_i) begin
                  chk = ST_BUDGET;
                end else if (meth_q[23:16] != 8'd0 || meth_q[15:8] != 8'd0 ||
                             meth_q[7:0] > 8'd1) begin
                  chk = ST_UNSUPPORTED;
                end else begin
                  seen_d[SeenIhdr] = 1'b1;
                end
              end else if (type_q == TypeIhdr) begin
                chk = ST_INVALID;
              end
              if (chk == ST_OK) begin
                if (type_q == TypeIdat) begin
                  seen_d[SeenIdat] = 1'b1;
                end
                if (type_q == TypeIend) begin
                  if (len_q != 32'd0 || !seen_q[SeenIdat]) begin
                    chk = ST_INVALID;
                  end else begin
                    seen_d[SeenIend] = 1'b1;
                  end
                end
              end
              err_d = chk;
            end
          end
          default: begin
            phase_d = PH_LENGTH;
          end
        endcase
      end
    end
  end

  always_comb begin
    fin = err_d;
    if (err_d == ST_OK && !seen_d[SeenIend]) begin
      fin = ST_INVALID;
    end
    res_o.status       = fin;
    res_o.image_width  = (fin == ST_OK) ? hw_d : 32'd0;
    res_o.image_height = (fin == ST_OK) ? hh_d : 32'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sig_cnt_q <= 4'd0;
      phase_q   <= PH_LENGTH;
      fcnt_q    <= 2'd0;
      len_q     <= 32'd0;
      rem_q     <= 32'd0;
      type_q    <= 32'd0;
      crc_q     <= CrcInit;
      scrc_q    <= 32'd0;
      hw_q      <= 32'd0;
      hh_q      <= 32'd0;
      meth_q    <= 24'd0;
      seen_q    <= 3'd0;
      err_q     <= ST_OK;
    end else if (step_i) begin
      if (last_i) begin
        sig_cnt_q <= 4'd0;
        phase_q   <= PH_LENGTH;
        fcnt_q    <= 2'd0;
        len_q     <= 32'd0;
        rem_q     <= 32'd0;
        type_q    <= 32'd0;
        crc_q     <= CrcInit;
        scrc_q    <= 32'd0;
        hw_q      <= 32'd0;
        hh_q      <= 32'd0;
        meth_q    <= 24'd0;
        seen_q    <= 3'd0;
        err_q     <= ST_OK;
      end else begin
        sig_cnt_q <= sig_cnt_d;
        phase_q   <= phase_d;
        fcnt_q    <= fcnt_d;
        len_q     <= len_d;
        rem_q     <= rem_d;
        type_q    <= type_d;
        crc_q     <= crc_d;
        scrc_q    <= scrc_d;
        hw_q      <= hw_d;
        hh_q      <= hh_d;
        meth_q    <= meth_d;
        seen_q    <= seen_d;
        err_q     <= err_d;
      end
    end
  end

  assign hdr_w_o = hw_q;
  assign hdr_h_o = hh_q;

endmodule

`default_nettype wire

// File: rtl/png_chunk_validator_core.sv
// Top level of the PNG chunk validator: input register, parser, budget check, result register.
// Depends on png_cv_pkg, png_cv_parser and png_cv_budget.
`default_nettype none

// Takes a PNG file one byte per transaction on the slave stream, tlast on the final byte,
// and gives one result transaction per file from the result register. A byte is taken
// every cycle: the input register feeds a combinational parser step (unrolled CRC-32 byte
// update and chunk checks), and a result register parts the output side. Input stalls only
// when a result is still held and the next byte is again a final byte. The pixel product
// is formed in a registered multiplier during the IHDR bytes that follow the height field.
// Write configuration only between files.
module png_chunk_validator_core
  import png_cv_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // data_byte [7:0]
  input  wire logic        s_axis_tlast,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [71:0]      m_axis_tdata,   // status [2:0], image_width [34:3],
                                           // image_height [66:35], zero [71:67]
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_addr_i,
  input  wire logic [62:0] cfg_data_i
);

  logic        in_valid_q;
  logic [7:0]  in_byte_q;
  logic        in_last_q;
  logic        out_valid_q;
  res_t        out_res_q;
  logic [31:0] max_dim_q;
  logic [62:0] max_pix_q;
  logic        advance;
  logic        s_accept;
  logic [31:0] hdr_w;
  logic [31:0] hdr_h;
  logic        over;
  res_t        res;

  assign advance       = in_valid_q && (!in_last_q || !out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_accept) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      in_byte_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_dim_q <= MaxDimReset;
      max_pix_q <= MaxPixReset;
    end else if (cfg_valid_i) begin
      if (cfg_addr_i == CfgMaxDim) begin
        max_dim_q <= cfg_data_i[31:0];
      end else if (cfg_addr_i == CfgMaxPix) begin
        max_pix_q <= cfg_data_i;
      end
    end
  end

  png_cv_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (advance),
    .byte_i    (in_byte_q),
    .last_i    (in_last_q),
    .max_dim_i (max_dim_q),
    .over_i    (over),
    .hdr_w_o   (hdr_w),
    .hdr_h_o   (hdr_h),
    .res_o     (res)
  );

  png_cv_budget u_budget (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .hdr_w_i   (hdr_w),
    .hdr_h_i   (hdr_h),
    .max_pix_i (max_pix_q),
    .over_o    (over)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && in_last_q) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_last_q) begin
      out_res_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'd0, out_res_q.image_height, out_res_q.image_width,
                          out_res_q.status};

`ifndef ASSERT_OFF
  a_zero_dims_on_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && out_res_q.status != ST_OK |->
      out_res_q.image_width == 32'd0 && out_res_q.image_height == 32'd0)
    else $error("nonzero dimensions with error status");
  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> out_res_q.status <= ST_UNSUPPORTED)
    else $error("status code out of range");
  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> in_valid_q && in_last_q && out_valid_q && !m_axis_tready)
    else $error("input stalled without a held result");
  a_result_follows_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && in_last_q |=> out_valid_q)
    else $error("final byte gave no result");
`endif

endmodule

`default_nettype wire

// File: tb/png_chunk_validator_core_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for png_chunk_validator_core: builds PNG byte streams, predicts
// each file's status and dimensions, and checks every result transaction against them.
// Depends on png_cv_pkg and the RTL of the block; needs no files or arguments.
module png_chunk_validator_core_tb;
  import png_cv_pkg::*;

  localparam logic [1:0]  CfgUnused    = 2'd3;
  localparam int          LongHold     = 200;
  localparam int          DrainLimit   = 4000;
  localparam int          SettleCycles = 8;
  localparam logic [31:0] NoFlip       = 32'd0;
  localparam logic [23:0] MethPlain    = 24'h00_00_00;
  localparam logic [23:0] MethLaced    = 24'h00_00_01;
  localparam logic [62:0] PixTop       = 63'h4000_0000_0000_0000;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'd0;
  logic        s_axis_tlast  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_addr_i    = 2'd0;
  logic [62:0] cfg_data_i    = 63'd0;

  int src_idle  = 0;
  int snk_stall = 0;
  int mismatches = 0;
  logic hold_arm  = 1'b0;
  logic hold_seen = 1'b0;
  int   hold_left = 0;

  logic [7:0] png_magic [8] = '{8'd137, 8'd80, 8'd78, 8'd71, 8'd13, 8'd10, 8'd26, 8'd10};

  logic [7:0] file_buf [$];
  logic [7:0] chunk_body [$];
  res_t       expected_results [$];

  // predictor state
  logic [31:0] lim_dim;
  logic [62:0] lim_pix;
  int          sig_cnt;
  phase_e      phase;
  int          fld_cnt;
  logic [31:0] chunk_len, data_left, chunk_kind, crc_acc, crc_rx, hdr_w, hdr_h;
  logic [23:0] hdr_meth;
  logic        seen_ihdr, seen_idat, seen_iend;
  status_e     err;

  png_chunk_validator_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("FAIL png_chunk_validator_core");
    $finish;
  end

  always @(posedge clk_i) begin
    if (hold_arm != hold_seen) begin
      hold_seen     <= hold_arm;
      hold_left     <= LongHold;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= snk_stall);
    end
  end

  always @(negedge clk_i) begin
    res_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.status       = status_e'(m_axis_tdata[2:0]);
      got.image_width  = m_axis_tdata[34:3];
      got.image_height = m_axis_tdata[66:35];
      if (expected_results.size() == 0) begin
        mismatches++;
        $error("result with no file pending: status %0d", got.status);
      end else begin
        want = expected_results.pop_front();
        if (got.status !== want.status) begin
          mismatches++;
          $error("status: expected %0d, actual %0d", want.status, got.status);
        end
        if (got.image_width !== want.image_width) begin
          mismatches++;
          $error("image_width: expected %0d, actual %0d", want.image_width, got.image_width);
        end
        if (got.image_height !== want.image_height) begin
          mismatches++;
          $error("image_height: expected %0d, actual %0d", want.image_height,
                 got.image_height);
        end
      end
    end
  end

  function automatic logic [31:0] crc_next(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] acc;
    acc = c ^ {24'd0, b};
    repeat (8) acc = acc[0] ? ((acc >> 1) ^ 32'hEDB8_8320) : (acc >> 1);
    return acc;
  endfunction

  task automatic clear_parser();
    sig_cnt    = 0;
    phase      = PH_LENGTH;
    fld_cnt    = 0;
    chunk_len  = '0;
    data_left  = '0;
    chunk_kind = '0;
    crc_acc    = CrcInit;
    crc_rx     = '0;
    hdr_w      = '0;
    hdr_h      = '0;
    hdr_meth   = '0;
    seen_ihdr  = 1'b0;
    seen_idat  = 1'b0;
    seen_iend  = 1'b0;
    err        = ST_OK;
  endtask

  function automatic status_e chunk_verdict();
    logic [63:0] area;
    if (~crc_acc != crc_rx) return ST_CRC;
    if (!seen_ihdr) begin
      if (chunk_kind != TypeIhdr || chunk_len != IhdrLen) return ST_INVALID;
      if (hdr_w == 0 || hdr_h == 0 || hdr_w > lim_dim || hdr_h > lim_dim) return ST_INVALID;
      area = {32'd0, hdr_w} * {32'd0, hdr_h};
      if (area > {1'b0, lim_pix}) return ST_BUDGET;
      if (hdr_meth[23:16] != 0 || hdr_meth[15:8] != 0 || hdr_meth[7:0] > 1)
        return ST_UNSUPPORTED;
      seen_ihdr = 1'b1;
    end else if (chunk_kind == TypeIhdr) begin
      return ST_INVALID;
    end
    if (chunk_kind == TypeIdat) seen_idat = 1'b1;
    if (chunk_kind == TypeIend) begin
      if (chunk_len != 0 || !seen_idat) return ST_INVALID;
      seen_iend = 1'b1;
    end
    return ST_OK;
  endfunction

  task automatic parse_byte(input logic [7:0] b);
    logic [31:0] idx;
    if (sig_cnt < 8) begin
      if (b != png_magic[sig_cnt]) err = ST_INVALID;
      else sig_cnt++;
    end else if (seen_iend) begin
      err = ST_INVALID;
    end else begin
      case (phase)
        PH_LENGTH: begin
          chunk_len = {chunk_len[23:0], b};
          fld_cnt++;
          if (fld_cnt == 4) begin
            fld_cnt = 0;
            phase   = PH_TYPE;
            crc_acc = CrcInit;
          end
        end
        PH_TYPE: begin
          chunk_kind = {chunk_kind[23:0], b};
          crc_acc    = crc_next(crc_acc, b);
          fld_cnt++;
          if (fld_cnt == 4) begin
            fld_cnt = 0;
            if (chunk_len == 0) begin
              phase = PH_CRC;
            end else begin
              phase     = PH_DATA;
              data_left = chunk_len;
            end
          end
        end
        PH_DATA: begin
          idx = chunk_len - data_left;
          if (!seen_ihdr) begin
            if (idx < 4) hdr_w = {hdr_w[23:0], b};
            else if (idx < 8) hdr_h = {hdr_h[23:0], b};
            else if (idx >= 10 && idx < 13) hdr_meth = {hdr_meth[15:0], b};
          end
          crc_acc   = crc_next(crc_acc, b);
          data_left = data_left - 32'd1;
          if (data_left == 0) phase = PH_CRC;
        end
        default: begin
          crc_rx = {crc_rx[23:0], b};
          fld_cnt++;
          if (fld_cnt == 4) begin
            fld_cnt = 0;
            phase   = PH_LENGTH;
            err     = chunk_verdict();
          end
        end
      endcase
    end
  endtask

  task automatic predict_byte(input logic [7:0] b, input logic last);
    res_t r;
    if (err == ST_OK) parse_byte(b);
    if (last) begin
      r.status       = (err == ST_OK && !seen_iend) ? ST_INVALID : err;
      r.image_width  = (r.status == ST_OK) ? hdr_w : 32'd0;
      r.image_height = (r.status == ST_OK) ? hdr_h : 32'd0;
      expected_results.push_back(r);
      clear_parser();
    end
  endtask

  task automatic send_byte(input logic [7:0] b, input logic last);
    logic rdy;
    while ($urandom_range(99) < src_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    do begin
      @(negedge clk_i);
      rdy = s_axis_tready;
      @(posedge clk_i);
    end while (!rdy);
    predict_byte(b, last);
  endtask

  task automatic send_file();
    for (int i = 0; i < file_buf.size(); i++) send_byte(file_buf[i], i == file_buf.size() - 1);
  endtask

  task automatic drain_results();
    int waited;
    waited = 0;
    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0 && waited < DrainLimit) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] addr, input logic [62:0] value);
    logic rdy;
    cfg_valid_i <= 1'b1;
    cfg_addr_i  <= addr;
    cfg_data_i  <= value;
    do begin
      @(negedge clk_i);
      rdy = cfg_ready_o;
      @(posedge clk_i);
    end while (!rdy);
    cfg_valid_i <= 1'b0;
    if (addr == CfgMaxDim) lim_dim = value[31:0];
    else if (addr == CfgMaxPix) lim_pix = value;
    @(posedge clk_i);
  endtask

  task automatic push_be32(input logic [31:0] v);
    for (int i = 3; i >= 0; i--) file_buf.push_back(v[8*i +: 8]);
  endtask

  task automatic begin_file();
    file_buf.delete();
    foreach (png_magic[i]) file_buf.push_back(png_magic[i]);
  endtask

  task automatic push_chunk(input logic [31:0] kind, input logic [31:0] flip);
    logic [31:0] crc;
    crc = CrcInit;
    push_be32(32'(chunk_body.size()));
    push_be32(kind);
    for (int i = 3; i >= 0; i--) crc = crc_next(crc, kind[8*i +: 8]);
    foreach (chunk_body[i]) begin
      file_buf.push_back(chunk_body[i]);
      crc = crc_next(crc, chunk_body[i]);
    end
    push_be32(~crc ^ flip);
  endtask

  task automatic push_ihdr(input logic [31:0] w, input logic [31:0] h, input logic [23:0] meth,
                           input logic [31:0] flip);
    chunk_body.delete();
    for (int i = 3; i >= 0; i--) chunk_body.push_back(w[8*i +: 8]);
    for (int i = 3; i >= 0; i--) chunk_body.push_back(h[8*i +: 8]);
    chunk_body.push_back(8'd8);
    chunk_body.push_back(8'($urandom_range(6)));
    for (int i = 2; i >= 0; i--) chunk_body.push_back(meth[8*i +: 8]);
    push_chunk(TypeIhdr, flip);
  endtask

  task automatic push_random_chunk(input logic [31:0] kind, input int len);
    chunk_body.delete();
    repeat (len) chunk_body.push_back(8'($urandom));
    push_chunk(kind, NoFlip);
  endtask

  task automatic build_image(input logic [31:0] w, input logic [31:0] h,
                             input logic [23:0] meth);
    begin_file();
    push_ihdr(w, h, meth, NoFlip);
    push_random_chunk(TypeIdat, 4);
    push_random_chunk(TypeIend, 0);
  endtask

  function automatic logic [31:0] random_dim();
    int sel;
    sel = $urandom_range(9);
    if (sel < 7) return 32'($urandom_range(1, 64));
    if (sel < 9) return 32'($urandom_range(1, 65535));
    return $urandom;
  endfunction

  task automatic build_random_file();
    int pick, shape, n_idat, cut;
    logic [31:0] w, h;
    logic [23:0] meth;
    pick = $urandom_range(99);
    if (pick >= 85) begin
      file_buf.delete();
      cut = $urandom_range(1, 12);
      for (int i = 0; i < cut; i++)
        file_buf.push_back((pick[0] && i < 8) ? png_magic[i] : 8'($urandom));
      return;
    end
    w     = random_dim();
    h     = random_dim();
    meth  = {23'd0, 1'($urandom_range(1))};
    if ($urandom_range(9) == 0) meth[8*$urandom_range(2) +: 8] = 8'($urandom);
    shape = $urandom_range(19);
    begin_file();
    push_ihdr(w, h, meth, NoFlip);
    if ($urandom_range(3) == 0) push_random_chunk($urandom, $urandom_range(0, 6));
    n_idat = (shape == 1) ? 0 : $urandom_range(1, 3);
    for (int i = 0; i < n_idat; i++) begin
      push_random_chunk(TypeIdat, $urandom_range(0, 10));
      if ($urandom_range(4) == 0) push_random_chunk($urandom, $urandom_range(0, 6));
    end
    if (shape == 0) push_ihdr(w, h, meth, NoFlip);
    if (shape == 2) push_random_chunk(TypeIend, $urandom_range(1, 3));
    else if (shape != 3) push_random_chunk(TypeIend, 0);
    if (pick >= 60 && pick < 68) begin
      cut = $urandom_range(0, file_buf.size() - 1);
      file_buf[cut] = file_buf[cut] ^ (8'd1 << $urandom_range(7));
    end else if (pick >= 68 && pick < 76) begin
      cut = $urandom_range(1, file_buf.size() - 1);
      while (file_buf.size() > cut) void'(file_buf.pop_back());
    end else if (pick >= 76) begin
      repeat ($urandom_range(1, 3)) file_buf.push_back(8'($urandom));
    end
  endtask

  task automatic test_well_formed();
    build_image(32'd1, 32'd1, MethPlain);
    send_file();
    begin_file();
    push_ihdr(32'd16384, 32'd4096, MethLaced, NoFlip);
    push_random_chunk(32'h7445_5874, 5);
    push_random_chunk(TypeIdat, 0);
    push_random_chunk(TypeIdat, 9);
    push_random_chunk(32'h7449_4D45, 0);
    push_random_chunk(TypeIend, 0);
    send_file();
  endtask

  task automatic test_signature();
    build_image(32'd3, 32'd3, MethPlain);
    file_buf[0] = 8'h00;
    send_file();
    build_image(32'd3, 32'd3, MethPlain);
    file_buf[7] = 8'hFF;
    send_file();
    file_buf.delete();
    file_buf.push_back(png_magic[0]);
    send_file();
    begin_file();
    send_file();
  endtask

  task automatic test_header_fields();
    begin_file();
    push_random_chunk(TypeIdat, 5);
    push_random_chunk(TypeIend, 0);
    send_file();
    begin_file();
    chunk_body.delete();
    repeat (12) chunk_body.push_back(8'd1);
    push_chunk(TypeIhdr, NoFlip);
    push_random_chunk(TypeIdat, 3);
    push_random_chunk(TypeIend, 0);
    send_file();
    build_image(32'd0, 32'd7, MethPlain);
    send_file();
    build_image(32'd7, 32'd0, MethPlain);
    send_file();
    build_image(32'd16385, 32'd1, MethPlain);
    send_file();
    build_image(32'd16384, 32'd4097, MethPlain);
    send_file();
    build_image(32'd5, 32'd5, 24'h01_00_00);
    send_file();
    build_image(32'd5, 32'd5, 24'h00_FF_00);
    send_file();
    build_image(32'd5, 32'd5, 24'h00_00_02);
    send_file();
  endtask

  task automatic test_crc();
    begin_file();
    push_ihdr(32'd9, 32'd9, MethPlain, 32'h0000_0001);
    push_random_chunk(TypeIdat, 4);
    push_random_chunk(TypeIend, 0);
    send_file();
    build_image(32'd9, 32'd9, MethPlain);
    file_buf[file_buf.size() - 17] = file_buf[file_buf.size() - 17] ^ 8'h80;
    send_file();
  endtask

  task automatic test_chunk_order();
    begin_file();
    push_ihdr(32'd4, 32'd4, MethPlain, NoFlip);
    push_random_chunk(TypeIdat, 2);
    push_ihdr(32'd4, 32'd4, MethPlain, NoFlip);
    push_random_chunk(TypeIend, 0);
    send_file();
    begin_file();
    push_ihdr(32'd4, 32'd4, MethPlain, NoFlip);
    push_random_chunk(TypeIend, 0);
    push_random_chunk(TypeIdat, 2);
    send_file();
    begin_file();
    push_ihdr(32'd4, 32'd4, MethPlain, NoFlip);
    push_random_chunk(TypeIdat, 2);
    push_random_chunk(TypeIend, 1);
    send_file();
    begin_file();
    push_ihdr(32'd4, 32'd4, MethPlain, NoFlip);
    push_random_chunk(TypeIdat, 2);
    send_file();
    build_image(32'd4, 32'd4, MethPlain);
    repeat (15) void'(file_buf.pop_back());
    send_file();
    build_image(32'd4, 32'd4, MethPlain);
    file_buf.push_back(8'h00);
    send_file();
  endtask

  task automatic test_limits();
    drain_results();
    write_reg(CfgMaxDim, 63'd1);
    write_reg(CfgMaxPix, 63'd1);
    build_image(32'd1, 32'd1, MethPlain);
    send_file();
    build_image(32'd2, 32'd1, MethPlain);
    send_file();
    drain_results();
    write_reg(CfgMaxDim, 63'h7FFF_FFFF_FFFF_FFFF);
    write_reg(CfgMaxPix, PixTop);
    build_image(32'h8000_0000, 32'h8000_0000, MethPlain);
    send_file();
    build_image(32'h8000_0000, 32'h8000_0001, MethPlain);
    send_file();
    build_image(32'hFFFF_FFFF, 32'hFFFF_FFFF, MethPlain);
    send_file();
    drain_results();
    write_reg(CfgUnused, 63'({$urandom, $urandom}));
    build_image(32'h8000_0000, 32'h8000_0000, MethLaced);
    send_file();
    drain_results();
    write_reg(CfgMaxDim, {31'd0, MaxDimReset});
    write_reg(CfgMaxPix, MaxPixReset);
  endtask

  task automatic test_backpressure();
    hold_arm <= ~hold_arm;
    repeat (24) begin
      file_buf.delete();
      file_buf.push_back(8'($urandom));
      send_file();
    end
    build_image(32'd2, 32'd3, MethPlain);
    send_file();
    drain_results();
  endtask

  task automatic test_random_traffic();
    int phase_bytes;
    for (int p = 0; p < 4; p++) begin
      drain_results();
      case (p)
        0: begin
          src_idle  = 0;
          snk_stall = 0;
          write_reg(CfgMaxDim, 63'($urandom_range(64, 16384)));
          write_reg(CfgMaxPix, 63'($urandom_range(4096, 1 << 24)));
        end
        1: begin
          src_idle  = 57;
          snk_stall = 0;
          write_reg(CfgMaxDim, 63'hFFFF_FFFF);
          write_reg(CfgMaxPix, PixTop);
        end
        2: begin
          src_idle  = 0;
          snk_stall = 57;
          write_reg(CfgMaxDim, 63'($urandom_range(8, 64)));
          write_reg(CfgMaxPix, 63'($urandom_range(16, 2048)));
        end
        default: begin
          src_idle  = 7;
          snk_stall = 7;
          write_reg(CfgMaxDim, 63'({$urandom, $urandom}) | 63'd1);
          write_reg(CfgMaxPix, 63'({$urandom, $urandom}) | 63'd1);
        end
      endcase
      phase_bytes = 0;
      while (phase_bytes < 190) begin
        build_random_file();
        send_file();
        phase_bytes += file_buf.size();
      end
    end
  endtask

  initial begin
    lim_dim = MaxDimReset;
    lim_pix = MaxPixReset;
    clear_parser();
    repeat (4) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;
    @(posedge clk_i);
    test_well_formed();
    test_signature();
    test_header_fields();
    test_crc();
    test_chunk_order();
    test_limits();
    test_backpressure();
    test_random_traffic();
    drain_results();
    if (expected_results.size() != 0)
      $error("%0d results never arrived", expected_results.size());
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("PASS png_chunk_validator_core");
    end else begin
      $display("FAIL png_chunk_validator_core");
    end
    $finish;
  end

endmodule
